// File: design/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// shared widths, angle table and pipeline word type for the complex to polar
// converter
// ----------------------------------------------------------------------------
package c2p_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ITERATIONS = 16;
	localparam int GUARD_BITS = 28;

	// x/y: input, sign flip, cordic gain below 2, guard bits
	localparam int XW      = DATA_WIDTH + GUARD_BITS + 3;
	localparam int SW      = 2 * DATA_WIDTH;
	localparam int RW      = DATA_WIDTH + 3;
	localparam int ZW      = 32;
	localparam int PH_SH   = ZW - DATA_WIDTH;
	localparam int NSTG    = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;
	localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

	localparam logic [ZW-1:0] Z_PI = 32'h8000_0000;

	// round(atan(2^-i) * 2^31 / pi)
	localparam logic [ZW-1:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic                  zero;
		logic [XW-1:0]         x;
		logic [XW-1:0]         y;
		logic [ZW-1:0]         z;
		logic [SW-1:0]         s;
		logic [DATA_WIDTH-1:0] root;
		logic [RW-1:0]         rem;
	} core_t;

endpackage

// File: design/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front
// half-plane fold, absolute values, squares and sum of squares (three stages)
// ----------------------------------------------------------------------------
module c2p_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [c2p_pkg::DATA_WIDTH-1:0]  re,
	input  logic [c2p_pkg::DATA_WIDTH-1:0]  im,
	output logic                            out_valid,
	output c2p_pkg::core_t                  out_word
);
	import c2p_pkg::*;

	logic                  neg;
	logic [XW-1:0]         x_sc, y_sc;
	logic [DATA_WIDTH-1:0] are, aim;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  zero_s1, zero_s2, zero_s3;
	logic [XW-1:0]         x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [ZW-1:0]         z_s1, z_s2, z_s3;
	logic [DATA_WIDTH-1:0] are_s1, aim_s1;
	logic [SW-1:0]         sqre_s2, sqim_s2, sum_s3;

	assign neg  = re[DATA_WIDTH-1];
	assign x_sc = {{(XW-DATA_WIDTH){re[DATA_WIDTH-1]}}, re} << GUARD_BITS;
	assign y_sc = {{(XW-DATA_WIDTH){im[DATA_WIDTH-1]}}, im} << GUARD_BITS;
	assign are  = re[DATA_WIDTH-1] ? (~re + 1'b1) : re;
	assign aim  = im[DATA_WIDTH-1] ? (~im + 1'b1) : im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// left half-plane: turn by pi before the rotations
			zero_s1 <= (re == '0) && (im == '0);
			x_s1    <= neg ? (~x_sc + 1'b1) : x_sc;
			y_s1    <= neg ? (~y_sc + 1'b1) : y_sc;
			z_s1    <= neg ? Z_PI : '0;
			are_s1  <= are;
			aim_s1  <= aim;

			zero_s2 <= zero_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			sqre_s2 <= SW'(are_s1) * SW'(are_s1);
			sqim_s2 <= SW'(aim_s1) * SW'(aim_s1);

			zero_s3 <= zero_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			sum_s3  <= sqre_s2 + sqim_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_word  = '{zero: zero_s3, x: x_s3, y: y_s3, z: z_s3, s: sum_s3,
		root: '0, rem: '0};

endmodule

// File: design/c2p_core.sv
// ----------------------------------------------------------------------------
// c2p_core
// unrolled cordic vectoring stages side by side with a bit-per-stage
// integer square root
// ----------------------------------------------------------------------------
module c2p_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  c2p_pkg::core_t in_word,
	output logic           out_valid,
	output c2p_pkg::core_t out_word
);
	import c2p_pkg::*;

	logic  vld_s  [1:NSTG];
	core_t pipe_s [1:NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		core_t                 cur, nxt;
		logic                  vld_in;
		logic [XW-1:0]         x_n, y_n;
		logic [ZW-1:0]         z_n;
		logic [DATA_WIDTH-1:0] root_n;
		logic [RW-1:0]         rem_n;

		if (k == 0) begin : g_head
			assign vld_in = in_valid;
			assign cur    = in_word;
		end else begin : g_tail
			assign vld_in = vld_s[k];
			assign cur    = pipe_s[k];
		end

		if (k < ITERATIONS) begin : g_cordic
			localparam logic [ZW-1:0] ANG = ATAN_TAB[k];
			logic signed [XW-1:0] xs, ys, dx, dy;
			logic                 y_pos;

			assign xs    = $signed(cur.x);
			assign ys    = $signed(cur.y);
			assign dx    = ys >>> k;
			assign dy    = xs >>> k;
			// y of zero counts as non-negative
			assign y_pos = !cur.y[XW-1];
			assign x_n   = y_pos ? (xs + dx) : (xs - dx);
			assign y_n   = y_pos ? (ys - dy) : (ys + dy);
			assign z_n   = y_pos ? (cur.z + ANG) : (cur.z - ANG);
		end else begin : g_cordic_idle
			assign x_n = cur.x;
			assign y_n = cur.y;
			assign z_n = cur.z;
		end

		if (k < DATA_WIDTH) begin : g_sqrt
			localparam int I = DATA_WIDTH - 1 - k;
			logic [RW-1:0] rem_sh, trial;
			logic          ge;

			assign rem_sh = {cur.rem[RW-3:0], cur.s[2*I+1 -: 2]};
			assign trial  = {{(RW-DATA_WIDTH-2){1'b0}}, cur.root, 2'b01};
			assign ge     = rem_sh >= trial;
			assign rem_n  = ge ? (rem_sh - trial) : rem_sh;
			assign root_n = {cur.root[DATA_WIDTH-2:0], ge};
		end else begin : g_sqrt_idle
			assign rem_n  = cur.rem;
			assign root_n = cur.root;
		end

		assign nxt = '{zero: cur.zero, x: x_n, y: y_n, z: z_n, s: cur.s,
			root: root_n, rem: rem_n};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[NSTG];
	assign out_word  = pipe_s[NSTG];

endmodule

// File: design/c2p_out.sv
// ----------------------------------------------------------------------------
// c2p_out
// magnitude rounding, phase rounding to output width and the output register
// ----------------------------------------------------------------------------
module c2p_out (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  c2p_pkg::core_t                  in_word,
	output logic                            valid,
	output logic [c2p_pkg::DATA_WIDTH-1:0]  magnitude,
	output logic [c2p_pkg::DATA_WIDTH-1:0]  phase,
	output logic                            phase_valid
);
	import c2p_pkg::*;

	logic                  round_up;
	logic [DATA_WIDTH-1:0] mag_n, ph_n;
	logic                  valid_q, pv_q;
	logic [DATA_WIDTH-1:0] mag_q, phase_q;

	// remainder s - n^2 above n means s > n^2 + n
	assign round_up = in_word.rem > RW'(in_word.root);
	assign mag_n    = in_word.root + DATA_WIDTH'(round_up);

	if (PH_SH > 0) begin : g_ph_round
		logic [ZW-1:0] z_r;
		assign z_r  = in_word.z + (ZW'(1) << (PH_SH - 1));
		assign ph_n = z_r[ZW-1:PH_SH];
	end else begin : g_ph_full
		assign ph_n = in_word.z[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q   <= mag_n;
			phase_q <= in_word.zero ? '0 : ph_n;
			pv_q    <= !in_word.zero;
		end
	end

	assign valid       = valid_q;
	assign magnitude   = mag_q;
	assign phase       = phase_q;
	assign phase_valid = pv_q;

endmodule

// File: design/complex_to_polar_top.sv
// ----------------------------------------------------------------------------
// complex_to_polar_top
// pipeline: 3 front stages + NSTG core stages + 1 output stage; throughput
// one word per cycle while the output is not stalled, the core depth
// being set by the larger of the cordic iteration count and the root width.
// a word waiting at the output with m_tready low freezes the whole pipeline;
// reset clears only valid bits.
// ----------------------------------------------------------------------------
module complex_to_polar_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [c2p_pkg::TDATA_W-1:0]  s_tdata,   // real_part, imag_part
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [c2p_pkg::TDATA_W-1:0]  m_tdata,   // magnitude, phase
	output logic [0:0]                   m_tuser    // phase_valid
);
	import c2p_pkg::*;

	logic                  en;
	logic                  front_valid, core_valid;
	core_t                 front_word, core_word;
	logic [DATA_WIDTH-1:0] magnitude, phase;
	logic                  phase_valid;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	c2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.re        (s_tdata[DATA_WIDTH-1:0]),
		.im        (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.out_valid (front_valid),
		.out_word  (front_word)
	);

	c2p_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_word   (front_word),
		.out_valid (core_valid),
		.out_word  (core_word)
	);

	c2p_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (core_valid),
		.in_word     (core_word),
		.valid       (m_tvalid),
		.magnitude   (magnitude),
		.phase       (phase),
		.phase_valid (phase_valid)
	);

	assign m_tdata = TDATA_W'({phase, magnitude});
	assign m_tuser = phase_valid;

	// zero input gives zero magnitude and zero phase
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[2*DATA_WIDTH-1:0] == '0)
		else $error("zero input word with nonzero result");

	// any nonzero input has magnitude of at least one
	a_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[DATA_WIDTH-1:0] != '0)
		else $error("nonzero input word with zero magnitude");

	// an output word leaves only through a handshake
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tvalid) && !$past(m_tready) |-> m_tvalid)
		else $error("output word dropped while stalled");

endmodule

// File: bench/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// watches both stream channels of the complex to polar converter, predicts the
// magnitude, phase and phase_valid of every accepted input word and compares
// them in order with the output words
// ----------------------------------------------------------------------------
module c2p_checker
	import c2p_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [TDATA_W-1:0]  s_tdata,   // real_part, imag_part
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [TDATA_W-1:0]  m_tdata,   // magnitude, phase
	input  logic [0:0]          m_tuser,   // phase_valid
	output int unsigned         mismatches,
	output int unsigned         pending
);

	typedef struct packed {
		logic [DATA_WIDTH-1:0]        magnitude;
		logic signed [DATA_WIDTH-1:0] phase;
		logic                         phase_valid;
	} polar_t;

	polar_t polar_q [$];

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res   = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v   = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic polar_t to_polar(input logic signed [DATA_WIDTH-1:0] re,
	                                    input logic signed [DATA_WIDTH-1:0] im);
		polar_t          r;
		longint          x, y, dx, dy;
		longint unsigned sq, n;
		logic [ZW-1:0]   z;
		r  = '0;
		sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
		n  = floor_root(sq);
		// round to nearest, an exact half is impossible
		if (sq > n * n + n)
			n = n + 1;
		if (re == 0 && im == 0)
			return r;
		r.magnitude = n[DATA_WIDTH-1:0];
		x = longint'(re) <<< GUARD_BITS;
		y = longint'(im) <<< GUARD_BITS;
		z = '0;
		// left half-plane: turn by pi first
		if (re < 0) begin
			x = -x;
			y = -y;
			z = Z_PI;
		end
		for (int i = 0; i < ITERATIONS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end
		end
		if (PH_SH > 0)
			z = z + (32'd1 << (PH_SH - 1));
		r.phase       = DATA_WIDTH'(z >> PH_SH);
		r.phase_valid = 1'b1;
		return r;
	endfunction

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	always @(posedge clk) begin
		polar_t want;
		polar_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.magnitude   = m_tdata[DATA_WIDTH-1:0];
				got.phase       = m_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
				got.phase_valid = m_tuser[0];
				if (polar_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: output word with nothing expected: mag %0d phase %0d pv %0b",
						         $time, got.magnitude, got.phase, got.phase_valid);
					mismatches <= mismatches + 1;
				end else begin
					want = polar_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("%0t: expected mag %0d phase %0d pv %0b, got mag %0d phase %0d pv %0b",
							         $time, want.magnitude, want.phase, want.phase_valid,
							         got.magnitude, got.phase, got.phase_valid);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				polar_q.push_back(to_polar(s_tdata[DATA_WIDTH-1:0],
				                           s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			pending <= polar_q.size();
		end
	end

endmodule

// File: bench/tb_complex_to_polar_top.sv
// ----------------------------------------------------------------------------
// tb_complex_to_polar_top
// drives directed corner samples and then about 1400 random complex samples
// into the converter with random gaps on both sides, one long output hold-off
// to back the pipeline up, and a gap-free tail; the checker does the compare
// ----------------------------------------------------------------------------
module tb_complex_to_polar_top;
	import c2p_pkg::*;

	localparam int RANDOM_WORDS = 1400;
	localparam int HOLD_CYCLES  = 240;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;    // real_part, imag_part
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;    // magnitude, phase
	logic [0:0]          m_tuser;    // phase_valid

	int unsigned mismatches;
	int unsigned pending;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;

	complex_to_polar_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	c2p_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h8001;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			4:       return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic logic [15:0] tiny_value();
		return 16'($signed($urandom_range(0, 8)) - 4);
	endfunction

	function automatic logic [TDATA_W-1:0] random_sample();
		logic [15:0] re, im;
		re = 16'($urandom);
		im = 16'($urandom);
		case ($urandom_range(0, 9))
			4: begin
				re = tiny_value();
				im = tiny_value();
			end
			5: begin
				if ($urandom_range(0, 1))
					re = '0;
				else
					im = '0;
			end
			6: begin
				re = corner_value();
				im = corner_value();
			end
			7: begin
				// close to the negative real axis, where the angle wraps
				re = 16'h8000 | re;
				im = tiny_value();
			end
			8: begin
				im = $urandom_range(0, 1) ? re : -re;
			end
			9: begin
				im = tiny_value();
			end
			default: ;
		endcase
		return {im, re};
	endfunction

	task automatic send_word(input logic [15:0] re, input logic [15:0] im);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {im, re};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// output side: random stall bursts plus one long hold-off on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [TDATA_W-1:0] w;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: zero, axes, diagonals, full-scale and the negative real axis
		send_word(16'h0000, 16'h0000);
		send_word(16'h7FFF, 16'h0000);
		send_word(16'h8000, 16'h0000);
		send_word(16'h0000, 16'h7FFF);
		send_word(16'h0000, 16'h8000);
		send_word(16'h0001, 16'h0000);
		send_word(16'hFFFF, 16'h0000);
		send_word(16'h0000, 16'h0001);
		send_word(16'h0000, 16'hFFFF);
		send_word(16'hFFFB, 16'h0000);
		send_word(16'h7FFF, 16'h7FFF);
		send_word(16'h8000, 16'h8000);
		send_word(16'h8000, 16'h7FFF);
		send_word(16'h7FFF, 16'h8000);
		send_word(16'h8000, 16'h0001);
		send_word(16'h8000, 16'hFFFF);
		send_word(16'hFFFF, 16'hFFFF);
		send_word(16'hFFFF, 16'h0001);
		send_word(16'h0003, 16'h0004);
		send_word(16'hFFFD, 16'hFFFC);
		send_word(16'h5555, 16'hAAAA);
		send_word(16'hAAAA, 16'h5555);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300)
				hold_req = 1'b1;
			if (i == RANDOM_WORDS - 400) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			w = random_sample();
			send_word(w[15:0], w[31:16]);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
